@@ sv/plbt_pkg.sv @@
`default_nettype none
package plbt_pkg;
	localparam int NUM_LEVELS = 8192;
	localparam int WINDOW_SIZE = 2048;
	localparam int SLIDE_STEP = 256;
	localparam int HANDLE_BITS = 16;
	localparam int SLOT_W = $clog2(NUM_LEVELS);
	localparam int WORD_W = 32;
	localparam int NUM_WORDS = NUM_LEVELS / WORD_W;
	localparam int WADDR_W = $clog2(NUM_WORDS);
	localparam int BIT_W = $clog2(WORD_W);

	typedef enum logic [2:0] {
		KIND_ADD    = 3'd0,
		KIND_REMOVE = 3'd1,
		KIND_CENTER = 3'd2,
		KIND_UP     = 3'd3,
		KIND_DOWN   = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_LOOK,
		ST_RES
	} state_t;

	typedef enum logic {
		CFG_SIDE = 1'b0,
		CFG_BASE = 1'b1
	} cfg_idx_t;
endpackage
`default_nettype wire

@@ sv/plbt_ram.sv @@
`default_nettype none
module plbt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ sv/price_ladder_best_tracker_unit.sv @@
`default_nettype none
// Channel  | Direction | Payload
// s_axis   | in        | tdata {handle, price, kind}, kind in the lowest bits
// m_axis   | out       | tdata {window_high, window_low, best_handle, best_px,
//          |           |        best_valid, accepted} packed from bit 0
// cfg      | in        | cfg_index (0 side_is_ask, 1 base_price), cfg_data
//
// Every item passes ST_READ (read the slot word), ST_LOOK (look up the best handle)
// and ST_RES (load the result register) on its way to a valid result.
// Remove of the best level: ST_SCAN also walks the 32-slot occupancy words toward
// the window edge, up to 65 inside the window, up to 256 across the whole ladder.
// After reset, ST_CLEAR zeroes all NUM_LEVELS/32 (256) occupancy memory words;
// a stalled result waits in the output register and holds off new items.
module price_ladder_best_tracker_unit
	import plbt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [55:0] s_axis_tdata,  // kind[2:0], price[34:3], handle[50:35]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [119:0]     m_axis_tdata,  // accepted, best_valid, best_px,
	                                         // best_handle, window_low, window_high
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);
	state_t st_q, st_d;
	logic side_q;
	logic [31:0] base_q, wlo_q, whi_q, bprice_q;
	logic bpres_q;
	logic [SLOT_W-1:0] bslot_q;
	logic [2:0] kind_q;
	logic [31:0] price_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic [WADDR_W-1:0] clr_q, scan_q;
	logic [32:0] lim_q;  // scan bound in slot index, as word/bit
	logic acc_q;
	logic [119:0] out_q;
	logic ovalid_q;

	// item decode
	logic [32:0] rel;
	logic inl;
	logic [SLOT_W-1:0] slot_idx;
	assign rel = {1'b0, price_q} - {1'b0, base_q};
	assign inl = !rel[32] && (rel[31:0] < 32'(NUM_LEVELS));
	assign slot_idx = rel[SLOT_W-1:0];

	// occupancy memory, 32 slots per word
	logic occ_we;
	logic [WADDR_W-1:0] occ_waddr, occ_raddr;
	logic [WORD_W-1:0] occ_wdata, occ_rdata;
	plbt_ram #(.WIDTH(WORD_W), .DEPTH(NUM_WORDS)) u_occ (
		.clk(clk), .we(occ_we), .waddr(occ_waddr), .wdata(occ_wdata),
		.raddr(occ_raddr), .rdata(occ_rdata)
	);
	logic hnd_we;
	logic [SLOT_W-1:0] hnd_raddr;
	logic [HANDLE_BITS-1:0] hnd_rdata;
	plbt_ram #(.WIDTH(HANDLE_BITS), .DEPTH(NUM_LEVELS)) u_hnd (
		.clk(clk), .we(hnd_we), .waddr(slot_idx), .wdata(handle_q),
		.raddr(hnd_raddr), .rdata(hnd_rdata)
	);

	logic [32:0] top;  // ladder top price clamped
	always_comb begin
		top = {1'b0, base_q} + 33'(NUM_LEVELS - 1);
		if (top[32]) top = 33'h0FFFFFFFF;
	end
	logic [BIT_W-1:0] sbit;
	assign sbit = slot_idx[BIT_W-1:0];
	logic bitset;
	assign bitset = occ_rdata[sbit];

	// scan: mask current word to candidates, pick nearest
	logic [WADDR_W-1:0] lim_w;
	logic [BIT_W-1:0] lim_b;
	logic lim_none;
	assign lim_none = lim_q[32];
	assign lim_w = lim_q[SLOT_W-1:BIT_W];
	assign lim_b = lim_q[BIT_W-1:0];
	logic [WORD_W-1:0] cand;
	logic found;
	logic [BIT_W-1:0] fbit;
	always_comb begin
		cand = occ_rdata;
		for (int i = 0; i < WORD_W; i++) begin
			if (side_q) begin
				if (scan_q == slot_idx[SLOT_W-1:BIT_W] && BIT_W'(i) <= sbit) cand[i] = 1'b0;
				if (scan_q == lim_w && BIT_W'(i) > lim_b) cand[i] = 1'b0;
			end else begin
				if (scan_q == slot_idx[SLOT_W-1:BIT_W] && BIT_W'(i) >= sbit) cand[i] = 1'b0;
				if (scan_q == lim_w && BIT_W'(i) < lim_b) cand[i] = 1'b0;
			end
		end
		if (lim_none) cand = '0;
		found = |cand;
		fbit = '0;
		if (side_q) begin
			for (int i = WORD_W - 1; i >= 0; i--) if (cand[i]) fbit = BIT_W'(i);
		end else begin
			for (int i = 0; i < WORD_W; i++) if (cand[i]) fbit = BIT_W'(i);
		end
	end
	logic scan_end;
	assign scan_end = lim_none || scan_q == lim_w;

	// scan bound as slot index; bit 32 marks an empty range
	logic [32:0] lim_d;
	always_comb begin
		logic [32:0] e;
		if (side_q) begin
			e = ({1'b0, whi_q} > top) ? top : {1'b0, whi_q};
			lim_d = e - {1'b0, base_q};
			if (e <= {1'b0, price_q}) lim_d[32] = 1'b1;
		end else begin
			e = ({1'b0, wlo_q} < {1'b0, base_q}) ? {1'b0, base_q} : {1'b0, wlo_q};
			lim_d = e - {1'b0, base_q};
			if (e >= {1'b0, price_q}) lim_d[32] = 1'b1;
		end
	end

	// window arithmetic
	logic [32:0] c_lo, c_hi, up_hi, dn_lo;
	logic c_ok, up_ok, dn_ok;
	always_comb begin
		c_lo = {1'b0, price_q} - 33'(WINDOW_SIZE / 2);
		c_hi = c_lo + 33'(WINDOW_SIZE - 1);
		c_ok = !c_lo[32] && c_lo[31:0] >= base_q && c_hi <= top;
		up_hi = {1'b0, whi_q} + 33'(SLIDE_STEP);
		up_ok = up_hi >= {1'b0, base_q} && up_hi <= top;
		dn_lo = {1'b0, wlo_q} - 33'(SLIDE_STEP);
		dn_ok = !dn_lo[32] && dn_lo[31:0] >= base_q && dn_lo <= top;
	end

	// item takes effect
	logic acc_d;
	always_comb begin
		case (kind_q)
			KIND_ADD:    acc_d = inl;
			KIND_REMOVE: acc_d = inl && bitset;
			KIND_CENTER: acc_d = c_ok;
			KIND_UP:     acc_d = up_ok;
			KIND_DOWN:   acc_d = dn_ok;
			default:     acc_d = 1'b0;
		endcase
	end

	logic in_fire, out_fire;
	assign s_axis_tready = (st_q == ST_IDLE) && !ovalid_q;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = out_q;

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_CLEAR: if (clr_q == WADDR_W'(NUM_WORDS - 1)) st_d = ST_IDLE;
			ST_IDLE:  if (in_fire) st_d = ST_READ;
			ST_READ: begin
				if (kind_q == KIND_REMOVE && inl && bitset && bpres_q && slot_idx == bslot_q)
					st_d = ST_SCAN;
				else st_d = ST_LOOK;
			end
			ST_SCAN:  if (found || scan_end) st_d = ST_LOOK;
			ST_LOOK:  st_d = ST_RES;
			ST_RES:   st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	// memory control
	logic upd_best_add;
	always_comb begin
		upd_best_add = !bpres_q || (side_q ? price_q < bprice_q : price_q > bprice_q);
		occ_we = 1'b0;
		occ_waddr = slot_idx[SLOT_W-1:BIT_W];
		occ_wdata = occ_rdata;
		occ_raddr = slot_idx[SLOT_W-1:BIT_W];
		hnd_we = 1'b0;
		hnd_raddr = bslot_q;
		case (st_q)
			ST_CLEAR: begin
				occ_we = 1'b1;
				occ_waddr = clr_q;
				occ_wdata = '0;
			end
			ST_IDLE: occ_raddr = WADDR_W'(s_axis_tdata[3+BIT_W +: WADDR_W] - base_q[BIT_W +: WADDR_W]
				- WADDR_W'(s_axis_tdata[3 +: BIT_W] < base_q[BIT_W-1:0]));
			ST_READ: begin
				if (kind_q == KIND_ADD && inl) begin
					occ_we = 1'b1;
					occ_wdata[sbit] = 1'b1;
					hnd_we = 1'b1;
				end else if (kind_q == KIND_REMOVE && inl && bitset) begin
					occ_we = 1'b1;
					occ_wdata[sbit] = 1'b0;
				end
				occ_raddr = slot_idx[SLOT_W-1:BIT_W];
			end
			ST_SCAN: occ_raddr = side_q ? scan_q + 1'b1 : scan_q - 1'b1;
			ST_LOOK: ;
			ST_RES: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			clr_q <= '0;
			side_q <= 1'b0;
			base_q <= '0;
			wlo_q <= '0;
			whi_q <= '0;
			bpres_q <= 1'b0;
			bslot_q <= '0;
			bprice_q <= '0;
			acc_q <= 1'b0;
			scan_q <= '0;
			lim_q <= '0;
			out_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_SIDE) side_q <= cfg_data[0];
				else base_q <= cfg_data;
			end
			if (out_fire) ovalid_q <= 1'b0;
			case (st_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_READ: begin
					acc_q <= acc_d;
					scan_q <= slot_idx[SLOT_W-1:BIT_W];
					lim_q <= lim_d;
					case (kind_q)
						KIND_ADD: if (inl && upd_best_add) begin
							bpres_q <= 1'b1;
							bslot_q <= slot_idx;
							bprice_q <= price_q;
						end
						KIND_REMOVE: if (inl && bitset) begin
							if (bpres_q && slot_idx == bslot_q) bpres_q <= 1'b0;
						end
						KIND_CENTER: if (c_ok) begin
							wlo_q <= c_lo[31:0];
							whi_q <= c_hi[31:0];
						end
						KIND_UP: if (up_ok) begin
							wlo_q <= wlo_q + 32'(SLIDE_STEP);
							whi_q <= up_hi[31:0];
						end
						KIND_DOWN: if (dn_ok) begin
							wlo_q <= dn_lo[31:0];
							whi_q <= whi_q - 32'(SLIDE_STEP);
						end
						default: ;
					endcase
				end
				ST_SCAN: begin
					if (found) begin
						bpres_q <= 1'b1;
						bslot_q <= {scan_q, fbit};
						bprice_q <= base_q + 32'({scan_q, fbit});
					end
					scan_q <= side_q ? scan_q + 1'b1 : scan_q - 1'b1;
				end
				ST_RES: begin
					ovalid_q <= 1'b1;
					out_q <= {6'd0, whi_q, wlo_q,
						bpres_q ? hnd_rdata : 16'd0,
						bpres_q ? bprice_q : 32'd0, bpres_q, acc_q};
				end
				default: ;
			endcase
		end
	end

	// capture item; the handle read for the result runs in ST_LOOK
	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q <= s_axis_tdata[2:0];
			price_q <= s_axis_tdata[34:3];
			handle_q <= s_axis_tdata[50:35];
		end
	end

	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> st_q == ST_READ) else $error("item not decoded");
	a_res_gives_out: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_RES |=> ovalid_q) else $error("result lost");
	a_no_in_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q |-> !s_axis_tready) else $error("overrun");
endmodule
`default_nettype wire

@@ sim/tb_price_ladder_best_tracker_unit.sv @@
`timescale 1ns / 100ps
module tb_price_ladder_best_tracker_unit;
	import plbt_pkg::*;

	localparam longint unsigned PRICE_TOP = 64'hFFFF_FFFF;

	// One expected result transfer, fields as they leave the block
	typedef struct {
		bit        accepted;
		bit        best_valid;
		bit [31:0] best_px;
		bit [15:0] best_handle;
		bit [31:0] window_low;
		bit [31:0] window_high;
	} ladder_view_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [55:0]  s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [119:0] m_axis_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic         cfg_index;
	logic [31:0]  cfg_data;

	price_ladder_best_tracker_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Shadow copy of the ladder, advanced once per accepted input transfer
	bit        ask_side;
	bit [31:0] ladder_base;
	bit        slot_full [NUM_LEVELS];
	bit [15:0] slot_tag [NUM_LEVELS];
	bit        top_present;
	bit [12:0] top_slot;
	bit [31:0] top_price;
	bit [31:0] win_lo;
	bit [31:0] win_hi;

	ladder_view_t pending_views[$];
	int           fail_count;
	int           burst_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("price_ladder_best_tracker_unit regression: fail");
		$finish;
	end

	function automatic bit on_ladder(longint unsigned p);
		return p >= ladder_base && p - ladder_base < NUM_LEVELS;
	endfunction

	function automatic void take_best(longint unsigned p);
		top_present = 1'b1;
		top_slot = 13'(p - ladder_base);
		top_price = 32'(p);
	endfunction

	// Apply one item to the shadow ladder and return the view it leaves behind
	function automatic ladder_view_t ladder_apply(bit [2:0] kind, bit [31:0] price,
			bit [15:0] handle);
		ladder_view_t   v;
		longint unsigned p, lo, hi, q, top;
		bit             ok;
		p = price;
		ok = 1'b0;
		top = longint'(ladder_base) + NUM_LEVELS - 1;
		if (top > PRICE_TOP)
			top = PRICE_TOP;
		case (kind)
			KIND_ADD: if (on_ladder(p)) begin
				ok = 1'b1;
				slot_full[p - ladder_base] = 1'b1;
				slot_tag[p - ladder_base] = handle;
				if (!top_present || (ask_side ? p < top_price : p > top_price))
					take_best(p);
			end
			KIND_REMOVE: if (on_ladder(p) && slot_full[p - ladder_base]) begin
				ok = 1'b1;
				slot_full[p - ladder_base] = 1'b0;
				if (top_present && 13'(p - ladder_base) == top_slot) begin
					// scan toward worse prices, stop at the window edge
					top_present = 1'b0;
					if (ask_side) begin
						hi = (win_hi > top) ? top : win_hi;
						for (q = p + 1; q <= hi; q++)
							if (slot_full[q - ladder_base]) begin
								take_best(q);
								break;
							end
					end else begin
						lo = (win_lo < ladder_base) ? ladder_base : win_lo;
						for (q = p; q > lo; q--)
							if (slot_full[q - 1 - ladder_base]) begin
								take_best(q - 1);
								break;
							end
					end
				end
			end
			KIND_CENTER: if (p >= WINDOW_SIZE / 2) begin
				lo = p - WINDOW_SIZE / 2;
				hi = lo + WINDOW_SIZE - 1;
				if (on_ladder(lo) && on_ladder(hi) && hi <= PRICE_TOP) begin
					ok = 1'b1;
					win_lo = 32'(lo);
					win_hi = 32'(hi);
				end
			end
			KIND_UP: begin
				hi = longint'(win_hi) + SLIDE_STEP;
				if (hi <= PRICE_TOP && on_ladder(hi)) begin
					ok = 1'b1;
					win_lo = win_lo + SLIDE_STEP;
					win_hi = 32'(hi);
				end
			end
			KIND_DOWN: if (win_lo >= SLIDE_STEP && on_ladder(win_lo - SLIDE_STEP)) begin
				ok = 1'b1;
				win_lo = win_lo - SLIDE_STEP;
				win_hi = win_hi - SLIDE_STEP;
			end
			default: ok = 1'b0;
		endcase
		v.accepted = ok;
		v.best_valid = top_present;
		v.best_px = top_present ? top_price : 32'd0;
		v.best_handle = top_present ? slot_tag[top_slot] : 16'd0;
		v.window_low = win_lo;
		v.window_high = win_hi;
		return v;
	endfunction

	// Send one item; the sender may idle between bursts of random length
	task automatic send_item(bit [2:0] kind, bit [31:0] price, bit [15:0] handle);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'd0, handle, price, kind};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_views.push_back(ladder_apply(kind, price, handle));
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_views.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, bit [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_SIDE)
			ask_side = value[0];
		else
			ladder_base = value;
		@(posedge clk);
	endtask

	task automatic set_ladder(bit ask, bit [31:0] base);
		wait_drained();
		write_reg(CFG_SIDE, {31'd0, ask});
		write_reg(CFG_BASE, base);
	endtask

	// Pick a price near the live window so removes hit occupied slots often
	function automatic bit [31:0] pick_price();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return win_lo + $urandom_range(0, 63);
		else if (r < 80)
			return win_lo + $urandom_range(0, WINDOW_SIZE - 1);
		else if (r < 92)
			return win_lo - 128 + $urandom_range(0, WINDOW_SIZE + 255);
		return $urandom;
	endfunction

	task automatic test_bid_directed();
		set_ladder(1'b0, 32'd1000);
		send_item(KIND_ADD, 32'd999, 16'h1234);           // below the ladder
		send_item(KIND_ADD, 32'd1000, 16'hFFFF);          // slot zero
		send_item(KIND_ADD, 32'd1000 + NUM_LEVELS, 16'h1); // just above the ladder
		send_item(KIND_ADD, 32'd1000 + NUM_LEVELS - 1, 16'h0000);
		send_item(KIND_ADD, 32'd1000 + NUM_LEVELS - 1, 16'hA5A5); // handle replaced
		send_item(KIND_REMOVE, 32'd1500, 16'h0);          // empty slot
		send_item(KIND_REMOVE, 32'd1000 + NUM_LEVELS - 1, 16'h0); // best gone, scan
		send_item(KIND_CENTER, 32'd100, 16'h0);           // below half window
		send_item(KIND_CENTER, 32'd1000 + 1024, 16'h0);   // window at the ladder floor
		send_item(KIND_DOWN, 32'd0, 16'h0);               // refused at the floor
		send_item(KIND_UP, 32'd0, 16'h0);
		send_item(KIND_ADD, 32'd1300, 16'h5A5A);
		send_item(KIND_ADD, 32'd1100, 16'h0F0F);          // worse than best
		send_item(KIND_REMOVE, 32'd1300, 16'h0);          // scan stops at window edge
		send_item(KIND_DOWN, 32'd0, 16'h0);
		send_item(KIND_CENTER, 32'd1000 + NUM_LEVELS - 1024, 16'h0); // top edge fits
		send_item(KIND_CENTER, 32'd1000 + NUM_LEVELS - 1023, 16'h0); // one past
		send_item(KIND_UP, 32'd0, 16'h0);                 // refused at the top
		send_item(3'd5, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(3'd6, 32'd0, 16'h0);
		send_item(3'd7, 32'd1200, 16'h1);
		send_item(KIND_ADD, 32'hFFFF_FFFF, 16'h8000);
	endtask

	task automatic test_ask_top_directed();
		set_ladder(1'b1, 32'hFFFF_F000);
		send_item(KIND_ADD, 32'hFFFF_FFFF, 16'h7FFF);     // highest price
		send_item(KIND_ADD, 32'hFFFF_F000, 16'h0001);     // better ask
		send_item(KIND_CENTER, 32'hFFFF_FC00, 16'h0);     // window ends at the max
		send_item(KIND_CENTER, 32'hFFFF_FC01, 16'h0);     // would pass the max
		send_item(KIND_UP, 32'd0, 16'h0);
		send_item(KIND_ADD, 32'hFFFF_FA00, 16'h2222);
		send_item(KIND_REMOVE, 32'hFFFF_FA00, 16'h0);     // not the best ask, no scan
		send_item(KIND_REMOVE, 32'hFFFF_FFFF, 16'h0);     // not the best ask either, no scan
		set_ladder(1'b1, 32'hFFFF_FFFF);                  // single-slot ladder
		send_item(KIND_ADD, 32'hFFFF_FFFF, 16'h3333);
		send_item(KIND_DOWN, 32'd0, 16'h0);
		send_item(KIND_REMOVE, 32'hFFFF_FFFF, 16'h0);
	endtask

	task automatic test_random_traffic();
		bit [31:0] bases [6] = '{32'd0, 32'd4000, 32'h8000_0000, 32'd0,
			32'hFFFF_E000, 32'd123457};
		int        n, r;
		bit [2:0]  kind;
		for (int ph = 0; ph < 6; ph++) begin
			set_ladder(ph[0], bases[ph]);
			send_item(KIND_CENTER, bases[ph] + $urandom_range(1024, NUM_LEVELS - 1024),
				16'h0);
			for (n = 0; n < 300; n++) begin
				if (ph == 2 && n == 150)
					wait_drained();
				r = $urandom_range(0, 99);
				if (r < 46)
					kind = KIND_ADD;
				else if (r < 82)
					kind = KIND_REMOVE;
				else if (r < 87)
					kind = KIND_CENTER;
				else if (r < 92)
					kind = KIND_UP;
				else if (r < 97)
					kind = KIND_DOWN;
				else
					kind = 3'($urandom_range(5, 7));
				send_item(kind, (kind == KIND_CENTER && $urandom_range(0, 1)) ?
					ladder_base + $urandom_range(0, NUM_LEVELS) : pick_price(),
					16'($urandom));
			end
		end
	endtask

	// Receiver stalls: switch between free flow and random stalls now and then
	int stall_mode;
	int stall_left;
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(20, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			default: m_axis_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		ladder_view_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_views.size() == 0) begin
				$error("result transfer with no expectation pending");
				fail_count++;
			end else begin
				want = pending_views.pop_front();
				if (m_axis_tdata[0] !== want.accepted) begin
					$error("accepted: expected %0d, got %0d", want.accepted, m_axis_tdata[0]);
					fail_count++;
				end
				if (m_axis_tdata[1] !== want.best_valid) begin
					$error("best_valid: expected %0d, got %0d", want.best_valid,
						m_axis_tdata[1]);
					fail_count++;
				end
				if (m_axis_tdata[33:2] !== want.best_px) begin
					$error("best_px: expected %h, got %h", want.best_px,
						m_axis_tdata[33:2]);
					fail_count++;
				end
				if (m_axis_tdata[49:34] !== want.best_handle) begin
					$error("best_handle: expected %h, got %h", want.best_handle,
						m_axis_tdata[49:34]);
					fail_count++;
				end
				if (m_axis_tdata[81:50] !== want.window_low) begin
					$error("window_low: expected %h, got %h", want.window_low,
						m_axis_tdata[81:50]);
					fail_count++;
				end
				if (m_axis_tdata[113:82] !== want.window_high) begin
					$error("window_high: expected %h, got %h", want.window_high,
						m_axis_tdata[113:82]);
					fail_count++;
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_SIDE;
		cfg_data <= '0;
		m_axis_tready = 1'b0;
		stall_mode = 0;
		stall_left = 0;
		fail_count = 0;
		burst_left = 0;
		ask_side = 1'b0;
		ladder_base = '0;
		top_present = 1'b0;
		top_slot = '0;
		top_price = '0;
		win_lo = '0;
		win_hi = '0;
		foreach (slot_full[i]) begin
			slot_full[i] = 1'b0;
			slot_tag[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_bid_directed();
		test_ask_top_directed();
		test_random_traffic();

		wait_drained();
		if (fail_count == 0 && pending_views.size() == 0)
			$display("price_ladder_best_tracker_unit regression: pass");
		else
			$display("price_ladder_best_tracker_unit regression: fail");
		$finish;
	end
endmodule
